// File: rtl/irad_pkg.sv
package irad_pkg;

   // default operand width of the radical engine
   localparam int VALUE_BITS_DEFAULT = 31;

endpackage

// File: rtl/irad_divider.sv
// restoring divider, one quotient bit per cycle
module irad_divider
   import irad_pkg::*;
#(
   parameter int NUM_BITS = VALUE_BITS_DEFAULT,
   parameter int DEN_BITS = (VALUE_BITS_DEFAULT + 1) / 2 + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient,
   output logic [DEN_BITS-1:0] remainder
);

   localparam int CNT_BITS = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

   logic                busy_ff;
   logic                busy_in;
   logic                done_ff;
   logic                done_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic [NUM_BITS-1:0] quo_ff;
   logic [NUM_BITS-1:0] quo_in;
   logic [DEN_BITS-1:0] rem_ff;
   logic [DEN_BITS-1:0] rem_in;
   logic [DEN_BITS-1:0] den_ff;
   logic [DEN_BITS-1:0] den_in;

   logic [DEN_BITS:0]   shifted;
   logic [DEN_BITS:0]   diff;

   // trial subtract of the divisor from the partial remainder
   assign shifted = {rem_ff, quo_ff[NUM_BITS-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(NUM_BITS - 1);
         quo_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         if (!diff[DEN_BITS]) begin
            rem_in = diff[DEN_BITS-1:0];
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_BITS-1:0];
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/irad_multiplier.sv
// shift-add multiplier, one multiplier bit per cycle, stops when no bits remain
module irad_multiplier
   import irad_pkg::*;
#(
   parameter int NUM_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] multiplicand,
   input  logic [NUM_BITS-1:0] multiplier,
   output logic                done,
   output logic [NUM_BITS-1:0] product
);

   logic                busy_ff;
   logic                busy_in;
   logic                done_ff;
   logic                done_in;
   logic [NUM_BITS-1:0] acc_ff;
   logic [NUM_BITS-1:0] acc_in;
   logic [NUM_BITS-1:0] mcand_ff;
   logic [NUM_BITS-1:0] mcand_in;
   logic [NUM_BITS-1:0] mplier_ff;
   logic [NUM_BITS-1:0] mplier_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         acc_in    = '0;
         mcand_in  = multiplicand;
         mplier_in = multiplier;
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            // product never exceeds the field, so truncation is safe
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[NUM_BITS-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[NUM_BITS-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: rtl/integer_radical.sv
// integer_radical: radical (product of distinct prime factors) by trial division
//
// request channel: req_tvalid/req_tready/req_tdata carries one value;
// a request is taken when tvalid and tready are both high. req_tready is high
// only while the engine is idle, so one request is worked on at a time.
// response channel: rsp_tvalid/rsp_tready/rsp_tdata carries the radical from an
// output register; the next request may be taken while a response still waits.
// cost: each trial divisor costs one division by the one-bit-per-cycle divider;
// a divisor that divides the remainder adds a shift-add multiply and one
// division per factor removed. divisors run from 2 up to sqrt of the remaining
// value, so the worst case is a prime near 2^31, which tries every divisor up
// to its square root. a value of zero answers zero without any division.
// reset clears the sequencer and drops rsp_tvalid; no table needs clearing.
// when the receiver stalls, the result holds in the output register and a
// finished computation waits until that register is free.
module integer_radical
   import irad_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [VALUE_BITS-1:0] value, upper bits zero padding
   input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [VALUE_BITS-1:0] radical, upper bits zero padding
   output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   // trial divisor never exceeds sqrt(2^VALUE_BITS) + 1
   localparam int DIV_BITS  = (VALUE_BITS + 1) / 2 + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TEST,
      S_MUL,
      S_STRIP,
      S_LAST,
      S_DONE
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   logic [VALUE_BITS-1:0] n_ff;        // remainder still to factor
   logic [VALUE_BITS-1:0] n_in;
   logic [DIV_BITS-1:0]   d_ff;        // current trial divisor
   logic [DIV_BITS-1:0]   d_in;
   logic [VALUE_BITS-1:0] prod_ff;     // radical so far
   logic [VALUE_BITS-1:0] prod_in;
   logic                  div_start_ff;
   logic                  div_start_in;
   logic                  mul_start_ff;
   logic                  mul_start_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_data_ff;
   logic [VALUE_BITS-1:0] rsp_data_in;

   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quo;
   logic [DIV_BITS-1:0]   div_rem;
   logic                  mul_done;
   logic [VALUE_BITS-1:0] mul_prod;
   logic [VALUE_BITS-1:0] mul_operand;
   logic [VALUE_BITS-1:0] req_value;

   assign req_value = req_tdata[VALUE_BITS-1:0];

   // last-prime multiply uses the leftover remainder, otherwise the divisor
   assign mul_operand = (state_ff == S_LAST) ? n_ff : VALUE_BITS'(d_ff);

   irad_divider #(
      .NUM_BITS (VALUE_BITS),
      .DEN_BITS (DIV_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   irad_multiplier #(
      .NUM_BITS (VALUE_BITS)
   ) u_multiplier (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start_ff),
      .multiplicand (prod_ff),
      .multiplier   (mul_operand),
      .done         (mul_done),
      .product      (mul_prod)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      prod_in      = prod_ff;
      div_start_in = 1'b0;
      mul_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // response taken by the receiver
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               n_in    = req_value;
               d_in    = DIV_BITS'(2);
               prod_in = VALUE_BITS'(1);
               if (req_value == '0) begin
                  // zero has no radical, answer zero
                  prod_in  = '0;
                  state_in = S_DONE;
               end else begin
                  div_start_in = 1'b1;
                  state_in     = S_TEST;
               end
            end
         end
         S_TEST: begin
            if (div_done) begin
               if (VALUE_BITS'(d_ff) > div_quo) begin
                  // divisor past sqrt of remainder: search over
                  if (n_ff > VALUE_BITS'(1)) begin
                     mul_start_in = 1'b1;
                     state_in     = S_LAST;
                  end else begin
                     state_in = S_DONE;
                  end
               end else if (div_rem == '0) begin
                  // new prime factor: take it once, then strip repeats
                  n_in         = div_quo;
                  mul_start_in = 1'b1;
                  state_in     = S_MUL;
               end else begin
                  d_in         = d_ff + 1'b1;
                  div_start_in = 1'b1;
               end
            end
         end
         S_MUL: begin
            if (mul_done) begin
               prod_in      = mul_prod;
               div_start_in = 1'b1;
               state_in     = S_STRIP;
            end
         end
         S_STRIP: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  n_in         = div_quo;
                  div_start_in = 1'b1;
               end else if (n_ff == VALUE_BITS'(1)) begin
                  // fully factored, stop early
                  state_in = S_DONE;
               end else begin
                  d_in         = d_ff + 1'b1;
                  div_start_in = 1'b1;
                  state_in     = S_TEST;
               end
            end
         end
         S_LAST: begin
            if (mul_done) begin
               prod_in  = mul_prod;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for a free output register
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = prod_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
         mul_start_ff <= mul_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      d_ff        <= d_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(rsp_data_ff);

endmodule
